### src/pfls_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the perspective floor line setup block
// no dependencies

package pfls_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 27;
   localparam int DIVIDEND_W  = 64;
   localparam int DIVISOR_W   = 32;
   localparam int LAST_CH     = 5;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_START,
      CS_WAIT,
      CS_OUT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      STEP_WX,
      STEP_WY,
      STEP_H2,
      STEP_HK,
      STEP_NK,
      STEP_DY,
      STEP_SY,
      STEP_SR,
      STEP_DP,
      STEP_SHI,
      STEP_SX,
      STEP_DXL,
      STEP_DXH,
      STEP_DDH,
      STEP_GR
   } step_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROW_COUNT,
      REG_EYE_HEIGHT,
      REG_NEAR_DISTANCE,
      REG_FAR_DISTANCE,
      REG_SCALE_PERCENT,
      REG_GRADIENT_START,
      REG_TINT_RGB
   } csr_reg_type;

   typedef struct packed {
      logic     capture_item;
      logic     div_start;
      logic     capture_result;
      step_type step;
      logic [2:0] chan;
   } pfls_cmd_type;

   typedef struct packed {
      logic req_kind;
      logic div_done;
      logic tint_en;
   } pfls_status_type;

endpackage

### src/pfls_if.sv
`timescale 1ns / 1ps
// channel interfaces: row request, row result and register write
// uses pfls_pkg for the register port widths

interface pfls_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [15:0] speed_x;
   logic signed [15:0] speed_y;
   logic [8:0]         row_index;
   modport source (output valid, kind, speed_x, speed_y, row_index, input ready);
   modport sink   (input valid, kind, speed_x, speed_y, row_index, output ready);
endinterface

interface pfls_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  source_row;
   logic [7:0]  start_int;
   logic [15:0] start_frac;
   logic [7:0]  step_int;
   logic [15:0] step_frac;
   logic [7:0]  add_red;
   logic [7:0]  add_green;
   logic [7:0]  add_blue;
   logic [7:0]  sub_red;
   logic [7:0]  sub_green;
   logic [7:0]  sub_blue;
   modport source (output valid, source_row, start_int, start_frac, step_int, step_frac,
                   add_red, add_green, add_blue, sub_red, sub_green, sub_blue,
                   input ready);
   modport sink   (input valid, source_row, start_int, start_frac, step_int, step_frac,
                   add_red, add_green, add_blue, sub_red, sub_green, sub_blue,
                   output ready);
endinterface

interface pfls_csr_if;
   logic                               valid;
   logic                               ready;
   logic [pfls_pkg::CSR_INDEX_W-1:0]   index;
   logic [pfls_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### src/perspective_floor_line_setup.sv
`timescale 1ns / 1ps
// top level of the perspective floor line setup block
// uses pfls_pkg, pfls_if, pfls_ctrl, pfls_datapath, pfls_divider
//
//   channel   dir  handshake      payload
//   req_chan  in   valid/ready    kind, speed_x, speed_y, row_index
//   rsp_chan  out  valid/ready    source_row .. sub_blue, one item per row request
//   csr_chan  in   valid/ready    index, data (ready held high)
//
// every step runs through one shared divider (start, the quotient bits in pairs,
// capture). an advance item takes 2 steps; a row item takes 12 steps, plus 6
// more when the tint gradient applies, before its result is offered.
// one item is in flight at a time; a stalled result holds the block until taken.
// reset restores the register defaults and zero scroll.

module perspective_floor_line_setup #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480,
   parameter int TEX_WIDTH     = 256,
   parameter int TEX_HEIGHT    = 256
) (
   input  logic       clock,
   input  logic       reset,
   pfls_req_if.sink   req_chan,
   pfls_rsp_if.source rsp_chan,
   pfls_csr_if.sink   csr_chan
);

   pfls_pkg::pfls_cmd_type    cmd;
   pfls_pkg::pfls_status_type status;

   assign csr_chan.ready = 1'b1;

   pfls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   pfls_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TEX_WIDTH     (TEX_WIDTH),
      .TEX_HEIGHT    (TEX_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_kind      (req_chan.kind),
      .req_speed_x   (req_chan.speed_x),
      .req_speed_y   (req_chan.speed_y),
      .req_row_index (req_chan.row_index),
      .csr_write     (csr_chan.valid),
      .csr_index     (csr_chan.index),
      .csr_data      (csr_chan.data),
      .source_row    (rsp_chan.source_row),
      .start_int     (rsp_chan.start_int),
      .start_frac    (rsp_chan.start_frac),
      .step_int      (rsp_chan.step_int),
      .step_frac     (rsp_chan.step_frac),
      .add_red       (rsp_chan.add_red),
      .add_green     (rsp_chan.add_green),
      .add_blue      (rsp_chan.add_blue),
      .sub_red       (rsp_chan.sub_red),
      .sub_green     (rsp_chan.sub_green),
      .sub_blue      (rsp_chan.sub_blue)
   );

endmodule

### src/pfls_divider.sv
`timescale 1ns / 1ps
// shared restoring divider, two quotient bits per cycle, 64 by 32 bits
// uses pfls_pkg for operand widths

module pfls_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [pfls_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [pfls_pkg::DIVISOR_W-1:0]     divisor,
   output logic                               done,
   output logic [pfls_pkg::DIVIDEND_W-1:0]    quotient,
   output logic [pfls_pkg::DIVISOR_W-1:0]     remainder
);

   localparam int DW = pfls_pkg::DIVIDEND_W;
   localparam int VW = pfls_pkg::DIVISOR_W;
   localparam int CNT_W = $clog2(DW / 2);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW / 2 - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    div_ff, div_in;

   logic [VW:0]   r1, r2;
   logic          ge1, ge2;
   logic [VW-1:0] r1n, r2n;

   always_comb begin
      r1  = {rem_ff, quo_ff[DW-1]};
      ge1 = r1 >= {1'b0, div_ff};
      r1n = ge1 ? VW'(r1 - {1'b0, div_ff}) : r1[VW-1:0];
      r2  = {r1n, quo_ff[DW-2]};
      ge2 = r2 >= {1'b0, div_ff};
      r2n = ge2 ? VW'(r2 - {1'b0, div_ff}) : r2[VW-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      done_in = busy_ff && (cnt_ff == CNT_LAST);
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-3:0], ge1, ge2};
         rem_in = r2n;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### src/pfls_datapath.sv
`timescale 1ns / 1ps
// datapath: registers, scroll state, operand selection for the divider,
// result capture and output assembly; uses pfls_pkg and pfls_divider

module pfls_datapath #(
   parameter int SCREEN_WIDTH  = 640,
   parameter int SCREEN_HEIGHT = 480,
   parameter int TEX_WIDTH     = 256,
   parameter int TEX_HEIGHT    = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pfls_pkg::pfls_cmd_type            cmd,
   output pfls_pkg::pfls_status_type         status,
   input  logic                              req_kind,
   input  logic signed [15:0]                req_speed_x,
   input  logic signed [15:0]                req_speed_y,
   input  logic [8:0]                        req_row_index,
   input  logic                              csr_write,
   input  logic [pfls_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pfls_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic [7:0]                        source_row,
   output logic [7:0]                        start_int,
   output logic [15:0]                       start_frac,
   output logic [7:0]                        step_int,
   output logic [15:0]                       step_frac,
   output logic [7:0]                        add_red,
   output logic [7:0]                        add_green,
   output logic [7:0]                        add_blue,
   output logic [7:0]                        sub_red,
   output logic [7:0]                        sub_green,
   output logic [7:0]                        sub_blue
);

   localparam int HALF   = SCREEN_WIDTH / 2;
   localparam int SX_MOD = TEX_WIDTH * 100;
   localparam int SY_MOD = TEX_HEIGHT * 100;
   localparam int SX_W   = $clog2(SX_MOD);
   localparam int SY_W   = $clog2(SY_MOD);
   localparam int SX_OFS = SX_MOD * ((32768 + SX_MOD - 1) / SX_MOD);
   localparam int SY_OFS = SY_MOD * ((32768 + SY_MOD - 1) / SY_MOD);
   localparam int TW_W   = $clog2(TEX_WIDTH + 1);
   localparam int L_MAX  = (SCREEN_HEIGHT > 511) ? 511 : SCREEN_HEIGHT;
   localparam logic [8:0]      L_MAX_V = 9'(L_MAX);
   localparam logic [TW_W-1:0] TW_V    = TW_W'(TEX_WIDTH);
   localparam int DW = pfls_pkg::DIVIDEND_W;
   localparam int VW = pfls_pkg::DIVISOR_W;

   // configuration
   logic [8:0]  row_count_ff, row_count_in;
   logic [15:0] eye_ff, eye_in;
   logic [15:0] near_ff, near_in;
   logic [15:0] far_ff, far_in;
   logic [9:0]  scale_ff, scale_in;
   logic [8:0]  gstart_ff, gstart_in;
   logic [26:0] tint_ff, tint_in;

   // scroll state
   logic [SX_W-1:0] scroll_x_ff, scroll_x_in;
   logic [SY_W-1:0] scroll_y_ff, scroll_y_in;

   // item and intermediate values
   logic signed [15:0] spx_ff, spx_in;
   logic signed [15:0] spy_ff, spy_in;
   logic [8:0]         idx_ff, idx_in;
   logic [31:0]        h2_ff, h2_in;
   logic [31:0]        hk_ff, hk_in;
   // depth reaches 2^32 when near is at its maximum and far is not above it, at the last row
   logic [32:0]        nk_ff, nk_in;
   logic [39:0]        dy_ff, dy_in;
   logic [35:0]        syq_ff, syq_in;
   logic [7:0]         srow_ff, srow_in;
   logic [55:0]        dp_ff, dp_in;
   logic [TW_W-1:0]    shi_ff, shi_in;
   logic [TW_W-1:0]    sxq_ff, sxq_in;
   logic [6:0]         sxr_ff, sxr_in;
   logic [16:0]        dxl_ff, dxl_in;
   logic [TW_W-1:0]    dxh_ff, dxh_in;
   logic [TW_W-1:0]    ddh_ff, ddh_in;
   logic [15:0]        ddl_ff, ddl_in;
   logic [7:0]         amt_ff [6];
   logic [7:0]         amt_in [6];

   // clamped configuration
   logic [8:0]  l_val;
   logic [15:0] h_val, d1_val;
   logic [16:0] d2_val;
   logic [9:0]  s_val;
   logic [8:0]  idx_val;
   logic [9:0]  n_val;
   logic        tint_en;
   logic [8:0]  c_val, v_val;

   // divider
   logic [DW-1:0] dividend;
   logic [VW-1:0] divisor;
   logic          div_done;
   logic [DW-1:0] quotient;
   logic [VW-1:0] remainder;

   logic [31:0] wx_sum, wy_sum;
   logic [32:0] hdiff;
   logic [31:0] hd, hs, den, dn;
   logic [39:0] dyd;
   logic [40:0] doty;
   logic [39:0] nk100;
   logic [32:0] slo_sum;
   logic [16:0] slo17;
   logic [15:0] slo;
   logic [31:0] ddl_full;
   logic [8:0]  t9, amt_src;
   logic [7:0]  q_sat;

   logic [TW_W-1:0] ddh_neg, ddh2;
   logic [16:0]     ddl2;
   logic [17:0]     sum_l;
   logic [TW_W+1:0] sum_h, sum_h2;

   function automatic logic [8:0] tint_amount(input logic [8:0] t, input logic want_sub);
      logic [8:0] r;
      if (t[8]) begin
         r = want_sub ? 9'(10'd512 - {1'b0, t}) : 9'd0;
      end else begin
         r = want_sub ? 9'd0 : t;
      end
      return r;
   endfunction

   always_comb begin
      if (row_count_ff == 9'd0) begin
         l_val = 9'd1;
      end else if (row_count_ff > L_MAX_V) begin
         l_val = L_MAX_V;
      end else begin
         l_val = row_count_ff;
      end
      h_val  = (eye_ff == 16'd0) ? 16'd1 : eye_ff;
      d1_val = (near_ff == 16'd0) ? 16'd1 : near_ff;
      d2_val = (far_ff <= d1_val) ? 17'({1'b0, d1_val} + 17'd1) : {1'b0, far_ff};
      s_val  = (scale_ff == 10'd0) ? 10'd1 : scale_ff;
      idx_val = (idx_ff > 9'(l_val - 9'd1)) ? 9'(l_val - 9'd1) : idx_ff;
      n_val   = 10'({1'b0, idx_val} + 10'd1);
      tint_en = (gstart_ff < l_val) && (idx_val >= gstart_ff);
      c_val   = 9'(idx_val - gstart_ff);
      v_val   = 9'(l_val - gstart_ff);
   end

   always_comb begin
      wx_sum  = 32'(scroll_x_ff) + 32'(spx_ff) + 32'(SX_OFS);
      wy_sum  = 32'(scroll_y_ff) + 32'(spy_ff) + 32'(SY_OFS);
      hdiff   = 33'(h_val) * 33'(d2_val - {1'b0, d1_val});
      hd      = 32'(h_val) * 32'(d1_val);
      hs      = {h_val, 16'h0};
      den     = (hs > hk_ff) ? 32'(hs - hk_ff) : 32'd1;
      dn      = {d1_val, 16'h0};
      dyd     = (nk_ff > {1'b0, dn}) ? 40'(40'(nk_ff - {1'b0, dn}) * 40'd100) : 40'd0;
      doty    = 41'(syq_ff) + 41'(dy_ff);
      nk100   = 40'(nk_ff) * 40'd100;
      slo_sum = {1'b0, dp_ff[31:0]} + 33'h8000;
      slo17   = slo_sum[32:16];
      slo     = slo17[16] ? 16'hffff : slo17[15:0];
      ddl_full = 32'(slo) * 32'(HALF);
      case (cmd.chan)
         3'd0, 3'd3: t9 = tint_ff[26:18];
         3'd1, 3'd4: t9 = tint_ff[17:9];
         default:    t9 = tint_ff[8:0];
      endcase
      amt_src = tint_amount(t9, cmd.chan >= 3'd3);
      q_sat   = (|quotient[DW-1:8]) ? 8'hff : quotient[7:0];
   end

   // operands for the current step
   always_comb begin
      dividend = '0;
      divisor  = VW'(1);
      case (cmd.step)
         pfls_pkg::STEP_WX: begin
            dividend = DW'(wx_sum);
            divisor  = VW'(SX_MOD);
         end
         pfls_pkg::STEP_WY: begin
            dividend = DW'(wy_sum);
            divisor  = VW'(SY_MOD);
         end
         pfls_pkg::STEP_H2: begin
            dividend = DW'({hdiff, 16'h0});
            divisor  = VW'(d2_val);
         end
         pfls_pkg::STEP_HK: begin
            dividend = DW'(42'(n_val) * 42'(h2_ff));
            divisor  = VW'(l_val);
         end
         pfls_pkg::STEP_NK: begin
            dividend = {hd, 32'h0};
            divisor  = den;
         end
         pfls_pkg::STEP_DY: begin
            dividend = DW'(dyd);
            divisor  = VW'(s_val);
         end
         pfls_pkg::STEP_SY: begin
            dividend = DW'({scroll_y_ff, 16'h0});
            divisor  = VW'(100);
         end
         pfls_pkg::STEP_SR: begin
            dividend = DW'(doty[40:16]);
            divisor  = VW'(TEX_HEIGHT);
         end
         pfls_pkg::STEP_DP: begin
            dividend = DW'({nk100, 16'h0});
            divisor  = VW'(26'(s_val) * 26'(d1_val));
         end
         pfls_pkg::STEP_SHI: begin
            dividend = DW'(dp_ff[55:32]);
            divisor  = VW'(TEX_WIDTH);
         end
         pfls_pkg::STEP_SX: begin
            dividend = DW'(scroll_x_ff);
            divisor  = VW'(100);
         end
         pfls_pkg::STEP_DXL: begin
            dividend = DW'({sxr_ff, 16'h0});
            divisor  = VW'(100);
         end
         pfls_pkg::STEP_DXH: begin
            dividend = DW'(HALF) + DW'(sxq_ff) + DW'(dxl_ff[16]);
            divisor  = VW'(TEX_WIDTH);
         end
         pfls_pkg::STEP_DDH: begin
            dividend = DW'(32'(shi_ff) * 32'(HALF)) + DW'(ddl_full[31:16]);
            divisor  = VW'(TEX_WIDTH);
         end
         pfls_pkg::STEP_GR: begin
            dividend = DW'(18'(amt_src) * 18'(c_val) + 18'(v_val[8:1]));
            divisor  = VW'(v_val);
         end
         default: begin
            dividend = '0;
            divisor  = VW'(1);
         end
      endcase
   end

   pfls_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // configuration writes
   always_comb begin
      row_count_in = row_count_ff;
      eye_in       = eye_ff;
      near_in      = near_ff;
      far_in       = far_ff;
      scale_in     = scale_ff;
      gstart_in    = gstart_ff;
      tint_in      = tint_ff;
      if (csr_write) begin
         case (pfls_pkg::csr_reg_type'(csr_index))
            pfls_pkg::REG_ROW_COUNT:      row_count_in = csr_data[8:0];
            pfls_pkg::REG_EYE_HEIGHT:     eye_in       = csr_data[15:0];
            pfls_pkg::REG_NEAR_DISTANCE:  near_in      = csr_data[15:0];
            pfls_pkg::REG_FAR_DISTANCE:   far_in       = csr_data[15:0];
            pfls_pkg::REG_SCALE_PERCENT:  scale_in     = csr_data[9:0];
            pfls_pkg::REG_GRADIENT_START: gstart_in    = csr_data[8:0];
            pfls_pkg::REG_TINT_RGB:       tint_in      = csr_data;
            default: ;
         endcase
      end
   end

   // item capture and step results
   always_comb begin
      scroll_x_in = scroll_x_ff;
      scroll_y_in = scroll_y_ff;
      spx_in  = spx_ff;
      spy_in  = spy_ff;
      idx_in  = idx_ff;
      h2_in   = h2_ff;
      hk_in   = hk_ff;
      nk_in   = nk_ff;
      dy_in   = dy_ff;
      syq_in  = syq_ff;
      srow_in = srow_ff;
      dp_in   = dp_ff;
      shi_in  = shi_ff;
      sxq_in  = sxq_ff;
      sxr_in  = sxr_ff;
      dxl_in  = dxl_ff;
      dxh_in  = dxh_ff;
      ddh_in  = ddh_ff;
      ddl_in  = ddl_ff;
      for (int k = 0; k < 6; k++) begin
         amt_in[k] = amt_ff[k];
      end
      if (cmd.capture_item) begin
         spx_in = req_speed_x;
         spy_in = req_speed_y;
         idx_in = req_row_index;
         for (int k = 0; k < 6; k++) begin
            amt_in[k] = 8'd0;
         end
      end
      if (cmd.capture_result) begin
         case (cmd.step)
            pfls_pkg::STEP_WX:  scroll_x_in = remainder[SX_W-1:0];
            pfls_pkg::STEP_WY:  scroll_y_in = remainder[SY_W-1:0];
            pfls_pkg::STEP_H2:  h2_in   = quotient[31:0];
            pfls_pkg::STEP_HK:  hk_in   = quotient[31:0];
            pfls_pkg::STEP_NK:  nk_in   = quotient[32:0];
            pfls_pkg::STEP_DY:  dy_in   = quotient[39:0];
            pfls_pkg::STEP_SY:  syq_in  = quotient[35:0];
            pfls_pkg::STEP_SR:  srow_in = remainder[7:0];
            pfls_pkg::STEP_DP:  dp_in   = quotient[55:0];
            pfls_pkg::STEP_SHI: shi_in  = remainder[TW_W-1:0];
            pfls_pkg::STEP_SX: begin
               sxq_in = quotient[TW_W-1:0];
               sxr_in = remainder[6:0];
            end
            pfls_pkg::STEP_DXL: dxl_in  = quotient[16:0];
            pfls_pkg::STEP_DXH: dxh_in  = remainder[TW_W-1:0];
            pfls_pkg::STEP_DDH: begin
               ddh_in = remainder[TW_W-1:0];
               ddl_in = ddl_full[15:0];
            end
            pfls_pkg::STEP_GR:  amt_in[cmd.chan] = q_sat;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= 9'd200;
         eye_ff       <= 16'd200;
         near_ff      <= 16'd100;
         far_ff       <= 16'd500;
         scale_ff     <= 10'd100;
         gstart_ff    <= 9'd480;
         tint_ff      <= '0;
         scroll_x_ff  <= '0;
         scroll_y_ff  <= '0;
      end else begin
         row_count_ff <= row_count_in;
         eye_ff       <= eye_in;
         near_ff      <= near_in;
         far_ff       <= far_in;
         scale_ff     <= scale_in;
         gstart_ff    <= gstart_in;
         tint_ff      <= tint_in;
         scroll_x_ff  <= scroll_x_in;
         scroll_y_ff  <= scroll_y_in;
      end
   end

   always_ff @(posedge clock) begin
      spx_ff  <= spx_in;
      spy_ff  <= spy_in;
      idx_ff  <= idx_in;
      h2_ff   <= h2_in;
      hk_ff   <= hk_in;
      nk_ff   <= nk_in;
      dy_ff   <= dy_in;
      syq_ff  <= syq_in;
      srow_ff <= srow_in;
      dp_ff   <= dp_in;
      shi_ff  <= shi_in;
      sxq_ff  <= sxq_in;
      sxr_ff  <= sxr_in;
      dxl_ff  <= dxl_in;
      dxh_ff  <= dxh_in;
      ddh_ff  <= ddh_in;
      ddl_ff  <= ddl_in;
      for (int k = 0; k < 6; k++) begin
         amt_ff[k] <= amt_in[k];
      end
   end

   // start x = scroll + half width - step * half width, 8.16 modulo texture width
   always_comb begin
      ddh_neg = (ddh_ff == '0) ? '0 : TW_W'(TW_V - ddh_ff);
      if (ddl_ff != 16'd0) begin
         ddh2 = (ddh_neg == '0) ? TW_W'(TW_V - 1'b1) : TW_W'(ddh_neg - 1'b1);
         ddl2 = 17'(17'h10000 - {1'b0, ddl_ff});
      end else begin
         ddh2 = ddh_neg;
         ddl2 = 17'd0;
      end
      sum_l  = 18'(dxl_ff) + 18'(ddl2);
      sum_h  = (TW_W+2)'(dxh_ff) + (TW_W+2)'(ddh2) + (TW_W+2)'(sum_l[17:16]);
      sum_h2 = (sum_h >= (TW_W+2)'(TEX_WIDTH)) ? (TW_W+2)'(sum_h - (TW_W+2)'(TEX_WIDTH))
                                               : sum_h;
   end

   assign source_row = srow_ff;
   assign start_int  = 8'(sum_h2);
   assign start_frac = sum_l[15:0];
   assign step_int   = 8'(shi_ff);
   assign step_frac  = slo;
   assign add_red    = amt_ff[0];
   assign add_green  = amt_ff[1];
   assign add_blue   = amt_ff[2];
   assign sub_red    = amt_ff[3];
   assign sub_green  = amt_ff[4];
   assign sub_blue   = amt_ff[5];

   assign status.req_kind = req_kind;
   assign status.div_done = div_done;
   assign status.tint_en  = tint_en;

endmodule

### src/pfls_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences the divider steps of one item and the handshakes
// uses pfls_pkg for state, step and command types

module pfls_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output pfls_pkg::pfls_cmd_type     cmd,
   input  pfls_pkg::pfls_status_type  status
);

   pfls_pkg::ctrl_state_type state_ff, state_in;
   pfls_pkg::step_type       step_ff, step_in;
   logic [2:0]               chan_ff, chan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfls_pkg::CS_IDLE;
         step_ff  <= pfls_pkg::STEP_WX;
         chan_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         chan_ff  <= chan_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      chan_in   = chan_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.step  = step_ff;
      cmd.chan  = chan_ff;
      case (state_ff)
         pfls_pkg::CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture_item = 1'b1;
               step_in  = status.req_kind ? pfls_pkg::STEP_H2 : pfls_pkg::STEP_WX;
               chan_in  = 3'd0;
               state_in = pfls_pkg::CS_START;
            end
         end
         pfls_pkg::CS_START: begin
            cmd.div_start = 1'b1;
            state_in      = pfls_pkg::CS_WAIT;
         end
         pfls_pkg::CS_WAIT: begin
            if (status.div_done) begin
               cmd.capture_result = 1'b1;
               state_in = pfls_pkg::CS_START;
               case (step_ff)
                  pfls_pkg::STEP_WY: begin
                     state_in = pfls_pkg::CS_IDLE;
                  end
                  pfls_pkg::STEP_DDH: begin
                     if (status.tint_en) begin
                        step_in = pfls_pkg::STEP_GR;
                     end else begin
                        state_in = pfls_pkg::CS_OUT;
                     end
                  end
                  pfls_pkg::STEP_GR: begin
                     if (chan_ff == 3'(pfls_pkg::LAST_CH)) begin
                        state_in = pfls_pkg::CS_OUT;
                     end else begin
                        chan_in = chan_ff + 3'd1;
                     end
                  end
                  default: begin
                     step_in = pfls_pkg::step_type'(step_ff + 4'd1);
                  end
               endcase
            end
         end
         pfls_pkg::CS_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = pfls_pkg::CS_IDLE;
            end
         end
         default: begin
            state_in = pfls_pkg::CS_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == pfls_pkg::CS_START))
      else $error("accepted item did not start the divider sequence");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == pfls_pkg::CS_WAIT))
      else $error("divider finished outside the wait state");
   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      chan_ff <= 3'(pfls_pkg::LAST_CH))
      else $error("tint channel counter out of range");
   a_start_from_idle_or_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfls_pkg::CS_START) |-> ($past(state_ff) == pfls_pkg::CS_IDLE ||
                                           $past(state_ff) == pfls_pkg::CS_WAIT))
      else $error("divider start entered from a wrong state");
`endif

endmodule

### sim/perspective_floor_line_setup_tb.sv
`timescale 1ns / 1ps
// testbench for the perspective floor line setup block: scroll advance and row setup
// depends on pfls_pkg, pfls_if and perspective_floor_line_setup from src

module perspective_floor_line_setup_tb;

   localparam int SCREEN_W   = 640;
   localparam int SCREEN_H   = 480;
   localparam int TEX_W      = 256;
   localparam int TEX_H      = 256;
   localparam int DRAIN_WAIT = 800;
   localparam int HOLD_LEN   = 3000;

   typedef struct {
      logic [7:0]  source_row;
      logic [7:0]  start_int;
      logic [15:0] start_frac;
      logic [7:0]  step_int;
      logic [15:0] step_frac;
      logic [7:0]  add_red;
      logic [7:0]  add_green;
      logic [7:0]  add_blue;
      logic [7:0]  sub_red;
      logic [7:0]  sub_green;
      logic [7:0]  sub_blue;
   } row_setup_type;

   class row_setup_board_type;
      int unsigned rows, eye, near, far, scale, grad_start, tint;
      int          scroll_x, scroll_y;
      row_setup_type pending_rows[$];
      int          errors;

      function void clear();
         rows = 200; eye = 200; near = 100; far = 500; scale = 100;
         grad_start = 480; tint = 0; scroll_x = 0; scroll_y = 0;
         errors = 0;
      endfunction

      function void write_reg(pfls_pkg::csr_reg_type idx, logic [26:0] value);
         case (idx)
            pfls_pkg::REG_ROW_COUNT:      rows = value[8:0];
            pfls_pkg::REG_EYE_HEIGHT:     eye = value[15:0];
            pfls_pkg::REG_NEAR_DISTANCE:  near = value[15:0];
            pfls_pkg::REG_FAR_DISTANCE:   far = value[15:0];
            pfls_pkg::REG_SCALE_PERCENT:  scale = value[9:0];
            pfls_pkg::REG_GRADIENT_START: grad_start = value[8:0];
            pfls_pkg::REG_TINT_RGB:       tint = value;
            default: ;
         endcase
      endfunction

      function int wrap(int pos, logic signed [15:0] speed, int size);
         int m, v;
         m = size * 100;
         v = (pos + int'(speed)) % m;
         if (v < 0) v += m;
         return v;
      endfunction

      function longint unsigned ramp(longint unsigned a, longint unsigned c, longint unsigned v);
         longint unsigned r;
         r = (a * c + v / 2) / v;
         return (r > 255) ? 255 : r;
      endfunction

      function void split_tint(logic [8:0] t, output longint unsigned add, output longint unsigned sub);
         if (t[8]) begin
            add = 0;
            sub = 512 - t;
         end else begin
            add = t;
            sub = 0;
         end
      endfunction

      function void note_item(logic kind, logic signed [15:0] sx, logic signed [15:0] sy,
                              logic [8:0] row_index);
         longint unsigned l, h, d1, d2, s, n, idx, h2, hk, den, num, q1, r1, nk, dn, dy;
         longint unsigned doty, dp, shi, slo, dxh, dxl, ddh, ddl, c, v;
         longint unsigned ar, ag, ab, sr, sg, sb;
         row_setup_type e;
         if (!kind) begin
            scroll_x = wrap(scroll_x, sx, TEX_W);
            scroll_y = wrap(scroll_y, sy, TEX_H);
            return;
         end
         l = rows;
         if (l < 1) l = 1;
         if (l > SCREEN_H) l = SCREEN_H;
         h = eye ? eye : 1;
         d1 = near ? near : 1;
         d2 = far;
         if (d2 <= d1) d2 = d1 + 1;
         s = scale ? scale : 1;
         idx = row_index;
         if (idx > l - 1) idx = l - 1;
         n = idx + 1;

         h2 = ((h * (d2 - d1)) << 16) / d2;
         hk = n * h2 / l;
         den = ((h << 16) > hk) ? (h << 16) - hk : 1;
         num = (h * d1) << 16;
         q1 = num / den;
         r1 = num % den;
         nk = (q1 << 16) + ((r1 << 16) / den);

         dn = d1 << 16;
         dy = (nk > dn) ? (nk - dn) * 100 / s : 0;
         doty = ((longint'(scroll_y) << 16) / 100) + dy;
         e.source_row = (doty >> 16) % TEX_H;

         dp = ((nk * 100) << 16) / (s * d1);
         shi = (dp >> 32) % TEX_W;
         slo = ((dp & 64'hffff_ffff) + 64'h8000) >> 16;
         if (slo > 65535) slo = 65535;

         // start x = scroll + half screen - step * half screen, wrapped to the texture
         dxh = SCREEN_W / 2 + scroll_x / 100;
         dxl = (longint'(scroll_x % 100) * 65536) / 100;
         dxh = (dxh + ((dxl >> 16) & 16'hffff)) % TEX_W;
         dxl &= 16'hffff;
         ddh = shi * (SCREEN_W / 2);
         ddl = slo * (SCREEN_W / 2);
         ddh = (ddh + ((ddl >> 16) & 16'hffff)) % TEX_W;
         ddl &= 16'hffff;
         ddh = (TEX_W - ddh) % TEX_W;
         if (ddl > 0) begin
            ddh = (ddh + TEX_W - 1) % TEX_W;
            ddl = 65536 - ddl;
         end
         dxh += ddh;
         dxl += ddl;
         dxh = (dxh + ((dxl >> 16) & 16'hffff)) % TEX_W;
         dxl &= 16'hffff;

         e.start_int = dxh;
         e.start_frac = dxl;
         e.step_int = shi;
         e.step_frac = slo;
         {e.add_red, e.add_green, e.add_blue, e.sub_red, e.sub_green, e.sub_blue} = '0;
         if (grad_start < l && idx >= grad_start) begin
            c = idx - grad_start;
            v = l - grad_start;
            split_tint(tint[26:18], ar, sr);
            split_tint(tint[17:9], ag, sg);
            split_tint(tint[8:0], ab, sb);
            e.add_red = ramp(ar, c, v);
            e.add_green = ramp(ag, c, v);
            e.add_blue = ramp(ab, c, v);
            e.sub_red = ramp(sr, c, v);
            e.sub_green = ramp(sg, c, v);
            e.sub_blue = ramp(sb, c, v);
         end
         pending_rows.push_back(e);
      endfunction

      function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check(row_setup_type got);
         row_setup_type e;
         if (pending_rows.size() == 0) begin
            $error("row result with no row item outstanding");
            errors++;
            return;
         end
         e = pending_rows.pop_front();
         cmp("source_row", e.source_row, got.source_row);
         cmp("start_int", e.start_int, got.start_int);
         cmp("start_frac", e.start_frac, got.start_frac);
         cmp("step_int", e.step_int, got.step_int);
         cmp("step_frac", e.step_frac, got.step_frac);
         cmp("add_red", e.add_red, got.add_red);
         cmp("add_green", e.add_green, got.add_green);
         cmp("add_blue", e.add_blue, got.add_blue);
         cmp("sub_red", e.sub_red, got.sub_red);
         cmp("sub_green", e.sub_green, got.sub_green);
         cmp("sub_blue", e.sub_blue, got.sub_blue);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   bit   hold_now;
   row_setup_board_type board;

   pfls_req_if req_chan ();
   pfls_rsp_if rsp_chan ();
   pfls_csr_if csr_chan ();

   perspective_floor_line_setup u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic send_item(logic kind, logic signed [15:0] sx, logic signed [15:0] sy,
                            logic [8:0] row_index);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= kind;
      req_chan.speed_x   <= sx;
      req_chan.speed_y   <= sy;
      req_chan.row_index <= row_index;
      do @(posedge clock); while (!req_chan.ready);
      board.note_item(kind, sx, sy, row_index);
   endtask

   // register writes only once every row result is back and the block has settled
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(pfls_pkg::csr_reg_type idx, logic [26:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      board.write_reg(idx, value);
   endtask

   task automatic set_regs(int unsigned rc, eh, nd, fd, sp, gs, tr);
      wait_idle();
      write_reg(pfls_pkg::REG_ROW_COUNT, 27'(rc));
      write_reg(pfls_pkg::REG_EYE_HEIGHT, 27'(eh));
      write_reg(pfls_pkg::REG_NEAR_DISTANCE, 27'(nd));
      write_reg(pfls_pkg::REG_FAR_DISTANCE, 27'(fd));
      write_reg(pfls_pkg::REG_SCALE_PERCENT, 27'(sp));
      write_reg(pfls_pkg::REG_GRADIENT_START, 27'(gs));
      write_reg(pfls_pkg::REG_TINT_RGB, 27'(tr));
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_items(int count);
      logic [8:0] row;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 3) begin
            send_item(1'b0, 16'($urandom), 16'($urandom), 9'($urandom));
         end else begin
            row = ($urandom_range(0, 7) == 0) ? 9'($urandom) :
                  9'($urandom_range(0, (board.rows > 1) ? board.rows - 1 : 0));
            send_item(1'b1, 16'($urandom), 16'($urandom), row);
         end
      end
   endtask

   // result side: random stalls, plus one long hold-off while the sender keeps offering
   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_now) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
            hold_now = 1'b0;
         end
         stall = calm ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin
      row_setup_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.source_row = rsp_chan.source_row;
         got.start_int  = rsp_chan.start_int;
         got.start_frac = rsp_chan.start_frac;
         got.step_int   = rsp_chan.step_int;
         got.step_frac  = rsp_chan.step_frac;
         got.add_red    = rsp_chan.add_red;
         got.add_green  = rsp_chan.add_green;
         got.add_blue   = rsp_chan.add_blue;
         got.sub_red    = rsp_chan.sub_red;
         got.sub_green  = rsp_chan.sub_green;
         got.sub_blue   = rsp_chan.sub_blue;
         board.check(got);
      end
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      board = new();
      board.clear();
      calm = 1'b0;
      hold_now = 1'b0;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.kind <= 1'b0;
      req_chan.speed_x <= '0;
      req_chan.speed_y <= '0;
      req_chan.row_index <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.index <= pfls_pkg::REG_ROW_COUNT;
      csr_chan.data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: rows at both ends, clamped index, speed extremes
      send_item(1'b1, 0, 0, 0);
      send_item(1'b1, 0, 0, 199);
      send_item(1'b1, 0, 0, 9'h1ff);
      send_item(1'b0, 16'sh7fff, -16'sh8000, 0);
      send_item(1'b1, 0, 0, 100);
      send_item(1'b0, -16'sh8000, 16'sh7fff, 0);
      send_item(1'b0, -16'sd1, 16'sd1, 0);
      send_item(1'b1, 0, 0, 50);

      // extremes: full height with gradient from row 0 and negative tints
      set_regs(480, 65535, 1, 65535, 1023, 0, 27'h7fc_0100);
      send_item(1'b1, 0, 0, 0);
      send_item(1'b1, 0, 0, 479);
      send_item(1'b1, 0, 0, 240);
      // zeros clamped up, far not above near, single row
      set_regs(0, 0, 0, 0, 0, 0, 27'h3ff_feff);
      send_item(1'b1, 0, 0, 0);
      send_item(1'b1, 0, 0, 9'h1ff);
      // row count above screen height, far below near, tint off
      set_regs(511, 1, 65535, 2, 1, 511, 27'h7ff_ffff);
      send_item(1'b1, 0, 0, 479);
      send_item(1'b1, 0, 0, 3);
      set_regs(480, 200, 100, 500, 1000, 479, 27'h7f3_fcff);
      send_item(1'b1, 0, 0, 479);
      send_item(1'b1, 0, 0, 478);

      // several random register settings, some phases with no idling
      for (int ph = 0; ph < 10; ph++) begin
         set_regs($urandom_range(1, 480), $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 1023),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 511) : $urandom_range(0, 100),
                  $urandom);
         calm = ($urandom_range(0, 3) == 0);
         if (ph == 2) hold_now = 1'b1;
         random_items(123);
      end
      calm = 1'b0;

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### filelist.f
src/pfls_pkg.sv
src/pfls_if.sv
src/pfls_divider.sv
src/pfls_datapath.sv
src/pfls_ctrl.sv
src/perspective_floor_line_setup.sv
sim/perspective_floor_line_setup_tb.sv
